FILE: rtl/assert_macros.svh
// assertion helpers for the checker file rrsp_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RRSP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rrsp assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define RRSP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rrsp assertion failed: next-cycle implication");

`endif

FILE: rtl/rrsp_pkg.sv
// ----------------------------------------------------------------------------
// rrsp_pkg
// shared types and codes of the resource record stream parser
// ----------------------------------------------------------------------------
`default_nettype none

package rrsp_pkg;

   // response kinds
   localparam logic [1:0] KIND_BODY  = 2'd0;
   localparam logic [1:0] KIND_EMPTY = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_BAD_LEN   = 3'd1;
   localparam logic [2:0] ERR_TRUNCATED = 3'd2;
   localparam logic [2:0] ERR_TOO_LONG  = 3'd3;
   localparam logic [2:0] ERR_ID_OVFL   = 3'd4;

   // request modes
   localparam logic MODE_DATA = 1'b0;
   localparam logic MODE_END  = 1'b1;

   localparam logic [27:0] MAX_LEN_RST = 28'h0100000;

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
   } rrsp_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [30:0] resource_type;
      logic [30:0] resource_id;
      logic [7:0]  body_byte;
      logic        first_of_record;
      logic        last_of_record;
      logic [2:0]  error_code;
   } rrsp_rsp_type;

   // compact queue entry: type kept as four 7-bit groups
   typedef struct packed {
      logic [1:0]  kind;
      logic [27:0] type_groups;
      logic [30:0] resource_id;
      logic [7:0]  body_byte;
      logic        first_of_record;
      logic        last_of_record;
      logic [2:0]  error_code;
   } rrsp_entry_type;

   // queue status toward the back end
   typedef struct packed {
      logic           empty;
      rrsp_entry_type head;
   } rrsp_qstat_type;

endpackage

`default_nettype wire

FILE: rtl/rrsp_front.sv
// ----------------------------------------------------------------------------
// rrsp_front
// header decoder: takes one stream byte a cycle while req_hs is high, keeps the parse state and
// posts at most one result entry per request into the queue
// ----------------------------------------------------------------------------
`default_nettype none

module rrsp_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_hs,
   input  wire rrsp_pkg::rrsp_req_type req_data,
   input  wire logic                 csr_hs,
   input  wire logic [27:0]          csr_wdata,
   output logic                      push,
   output rrsp_pkg::rrsp_entry_type  push_entry
);
   import rrsp_pkg::*;

   localparam logic [1:0] PH_ID   = 2'd0;
   localparam logic [1:0] PH_LEN  = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;

   logic [1:0]  phase_ff, phase_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [20:0] acc_ff, acc_in;
   logic [27:0] type_ff, type_in;
   logic [30:0] prev_id_ff, prev_id_in;
   logic [30:0] cur_id_ff, cur_id_in;
   logic [27:0] remain_ff, remain_in;
   logic        first_ff, first_in;
   logic [2:0]  err_ff, err_in;
   logic [27:0] max_len_ff;

   logic [7:0]  b;
   logic [27:0] vlq;
   logic [2:0]  cnt_inc;
   logic [31:0] id_sum;
   logic        body_last;

   assign b         = req_data.data_byte;
   assign vlq       = {acc_ff, b[6:0]};
   assign cnt_inc   = cnt_ff + 3'd1;
   assign id_sum    = {1'b0, prev_id_ff} + {4'b0, vlq};
   assign body_last = (remain_ff <= 28'd1);

   // parse step
   always_comb begin
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      acc_in     = acc_ff;
      type_in    = type_ff;
      prev_id_in = prev_id_ff;
      cur_id_in  = cur_id_ff;
      remain_in  = remain_ff;
      first_in   = first_ff;
      err_in     = err_ff;
      push       = 1'b0;
      push_entry.kind            = KIND_BODY;
      push_entry.type_groups     = type_ff;
      push_entry.resource_id     = cur_id_ff;
      push_entry.body_byte       = b;
      push_entry.first_of_record = 1'b0;
      push_entry.last_of_record  = 1'b0;
      push_entry.error_code      = ERR_NONE;

      if (req_hs) begin
         if (err_ff != ERR_NONE) begin
            push                  = 1'b1;
            push_entry.kind       = KIND_ERROR;
            push_entry.error_code = err_ff;
         end else if (req_data.mode == MODE_END) begin
            push = 1'b1;
            if (phase_ff == PH_ID && cnt_ff == 3'd0) begin
               push_entry.kind = KIND_END;
            end else begin
               err_in                = ERR_TRUNCATED;
               push_entry.kind       = KIND_ERROR;
               push_entry.error_code = ERR_TRUNCATED;
            end
         end else if (phase_ff == PH_BODY) begin
            push                       = 1'b1;
            push_entry.first_of_record = first_ff;
            push_entry.last_of_record  = body_last;
            first_in                   = 1'b0;
            if (remain_ff != 28'd0) begin
               remain_in = remain_ff - 28'd1;
            end
            if (body_last) begin
               phase_in = PH_ID;
            end
         end else if (b[7]) begin
            // continuation byte: keep collecting, close a type marker, or flag a bad length
            if (cnt_inc < 3'd4) begin
               cnt_in = cnt_inc;
               acc_in = {acc_ff[13:0], b[6:0]};
            end else if (phase_ff == PH_LEN) begin
               err_in                = ERR_BAD_LEN;
               push                  = 1'b1;
               push_entry.kind       = KIND_ERROR;
               push_entry.error_code = ERR_BAD_LEN;
            end else begin
               type_in    = vlq;
               prev_id_in = 31'd0;
               cnt_in     = 3'd0;
               acc_in     = 21'd0;
            end
         end else begin
            // final vlq byte
            cnt_in = 3'd0;
            acc_in = 21'd0;
            if (phase_ff == PH_LEN) begin
               if (vlq > max_len_ff) begin
                  err_in                = ERR_TOO_LONG;
                  push                  = 1'b1;
                  push_entry.kind       = KIND_ERROR;
                  push_entry.error_code = ERR_TOO_LONG;
               end else if (vlq == 28'd0) begin
                  phase_in                   = PH_ID;
                  push                       = 1'b1;
                  push_entry.kind            = KIND_EMPTY;
                  push_entry.first_of_record = 1'b1;
                  push_entry.last_of_record  = 1'b1;
               end else begin
                  remain_in = vlq;
                  first_in  = 1'b1;
                  phase_in  = PH_BODY;
               end
            end else if (id_sum[31]) begin
               err_in                = ERR_ID_OVFL;
               push                  = 1'b1;
               push_entry.kind       = KIND_ERROR;
               push_entry.error_code = ERR_ID_OVFL;
            end else begin
               prev_id_in = id_sum[30:0];
               cur_id_in  = id_sum[30:0];
               phase_in   = PH_LEN;
            end
         end
      end
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_ID;
         cnt_ff     <= 3'd0;
         acc_ff     <= 21'd0;
         type_ff    <= 28'd0;
         prev_id_ff <= 31'd0;
         cur_id_ff  <= 31'd0;
         remain_ff  <= 28'd0;
         first_ff   <= 1'b0;
         err_ff     <= ERR_NONE;
      end else begin
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
         acc_ff     <= acc_in;
         type_ff    <= type_in;
         prev_id_ff <= prev_id_in;
         cur_id_ff  <= cur_id_in;
         remain_ff  <= remain_in;
         first_ff   <= first_in;
         err_ff     <= err_in;
      end
   end

   // body length limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RST;
      end else if (csr_hs) begin
         max_len_ff <= csr_wdata;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/rrsp_queue.sv
// ----------------------------------------------------------------------------
// rrsp_queue
// small result queue between the header decoder and the output stage
// ----------------------------------------------------------------------------
`default_nettype none

module rrsp_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire rrsp_pkg::rrsp_entry_type push_entry,
   input  wire logic                 pop,
   output logic                      full,
   output rrsp_pkg::rrsp_qstat_type  qstat
);
   import rrsp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rrsp_entry_type   slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full        = (count_ff == CNT_W'(DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign qstat.head  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/rrsp_back.sv
// ----------------------------------------------------------------------------
// rrsp_back
// output stage: pulls entries from the queue, expands them into responses
// and holds each in the response register until it is taken
// ----------------------------------------------------------------------------
`default_nettype none

module rrsp_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rrsp_pkg::rrsp_qstat_type qstat,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rrsp_pkg::rrsp_rsp_type    rsp_data
);
   import rrsp_pkg::*;

   logic         valid_ff;
   rrsp_rsp_type data_ff, data_in;
   logic [27:0]  grp;

   assign grp       = qstat.head.type_groups;
   assign pop       = !qstat.empty && (!valid_ff || rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   // expand the entry into the response layout
   always_comb begin
      data_in.kind            = qstat.head.kind;
      data_in.resource_type   = {grp[27:21], 1'b0, grp[20:14], 1'b0,
                                 grp[13:7], 1'b0, grp[6:0]};
      data_in.resource_id     = qstat.head.resource_id;
      data_in.body_byte       = (qstat.head.kind == KIND_BODY) ?
                                qstat.head.body_byte : 8'd0;
      data_in.first_of_record = qstat.head.first_of_record;
      data_in.last_of_record  = qstat.head.last_of_record;
      data_in.error_code      = qstat.head.error_code;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!valid_ff || rsp_ready) begin
         valid_ff <= !qstat.empty;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/resource_record_stream_parser.sv
// ----------------------------------------------------------------------------
// resource_record_stream_parser
// parses a decompressed resource archive stream into per-byte body responses
// ----------------------------------------------------------------------------
// The parser takes one stream byte (or an end-of-stream request) per clock and
// gives at most one response for each request, in order. Sustained rate is one
// request per cycle while the queue has room; the header decoder handles each
// byte against its registered parse state. A response passes through a queue
// slot and then the output register before it shows on rsp_valid. The
// QUEUE_DEPTH-entry queue absorbs response backpressure; req_ready falls only
// while that queue is full. Errors latch until reset, and every later request
// then answers with the latched code. The body length limit is to be written
// through the csr port only while the block is idle; the block itself does
// not enforce this. csr_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module resource_record_stream_parser #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire rrsp_pkg::rrsp_req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rrsp_pkg::rrsp_rsp_type  rsp_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [27:0]        csr_wdata
);
   import rrsp_pkg::*;

   logic           req_hs;
   logic           csr_hs;
   logic           push;
   logic           pop;
   logic           full;
   rrsp_entry_type push_entry;
   rrsp_qstat_type qstat;

   assign req_ready = !full;
   assign req_hs    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_hs    = csr_valid && csr_ready;

   // header decoder
   rrsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_hs     (req_hs),
      .req_data   (req_data),
      .csr_hs     (csr_hs),
      .csr_wdata  (csr_wdata),
      .push       (push),
      .push_entry (push_entry)
   );

   // result queue
   rrsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .qstat      (qstat)
   );

   // output stage
   rrsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .qstat     (qstat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: rtl/rrsp_checker.sv
// ----------------------------------------------------------------------------
// rrsp_checker
// port-level checks on the parser's response stream
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rrsp_checker (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire rrsp_pkg::rrsp_rsp_type rsp_data
);
   import rrsp_pkg::*;

   logic err_seen_ff;
   logic rsp_stall;
   logic rsp_is_err;
   logic rsp_has_code;
   logic rsp_is_empty;
   logic rsp_both_marks;
   logic rsp_is_body;
   logic rsp_no_byte;

   assign rsp_stall      = rsp_valid && !rsp_ready;
   assign rsp_is_err     = (rsp_data.kind == KIND_ERROR);
   assign rsp_has_code   = (rsp_data.error_code != ERR_NONE);
   assign rsp_is_empty   = (rsp_data.kind == KIND_EMPTY);
   assign rsp_both_marks = rsp_data.first_of_record && rsp_data.last_of_record;
   assign rsp_is_body    = (rsp_data.kind == KIND_BODY);
   assign rsp_no_byte    = (rsp_data.body_byte == 8'd0);

   // remember that an error response has gone out
   always_ff @(posedge clock) begin
      if (reset) begin
         err_seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_is_err) begin
         err_seen_ff <= 1'b1;
      end
   end

   // a stalled response holds
   `RRSP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))

   // once an error has gone out, every later response is an error
   `RRSP_ASSERT_IMP(a_err_sticky, clock, reset, rsp_valid && err_seen_ff, rsp_is_err)

   // error code present exactly on error responses
   `RRSP_ASSERT_IMP(a_err_code, clock, reset, rsp_valid, rsp_is_err == rsp_has_code)

   // empty record is both first and last
   `RRSP_ASSERT_IMP(a_empty_marks, clock, reset, rsp_valid && rsp_is_empty, rsp_both_marks)

   // only body responses carry a byte
   `RRSP_ASSERT_IMP(a_byte_zero, clock, reset, rsp_valid && !rsp_is_body, rsp_no_byte)

endmodule

bind resource_record_stream_parser rrsp_checker u_checker (.*);

`default_nettype wire

FILE: sim/resource_record_stream_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resource_record_stream_parser_tb
// Self-checking bench for the resource record stream parser. Byte streams made
// of type markers, id and length VLQs and record bodies are fed through the
// request channel. A scoreboard predicts each response from its own model of
// the parser state, and responses are compared field by field. The body
// length limit changes between phases. The sender and receiver idle at
// several rates, and long receiver hold-offs back the block up. The run ends
// with one error, picked at random, and checks that the error stays latched.
// ----------------------------------------------------------------------------

module resource_record_stream_parser_tb;
   import rrsp_pkg::*;

   localparam int unsigned ID_LIMIT     = 32'h7fff_ffff;
   localparam int unsigned DELTA_MAX    = 32'h0fff_ffff;
   localparam logic [31:0] TYPE_MASK    = 32'h7f7f_7f7f;
   localparam logic [27:0] LEN_MAX      = 28'hfff_ffff;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          HOLD_CYCLES  = 400;
   localparam int          RANDOM_ITEMS = 1500;
   localparam int          PHASES       = 8;

   typedef enum logic [1:0] {AT_ID, AT_LENGTH, AT_BODY} parse_pos_type;

   // predicts parser responses and checks the ones the block gives
   class record_scoreboard;
      logic [27:0]   max_length;
      parse_pos_type pos;
      int            header_count;
      logic [31:0]   header_bytes;
      logic [31:0]   type_value;
      logic [30:0]   prev_id;
      logic [30:0]   cur_id;
      logic [27:0]   remaining;
      logic          first_pending;
      logic [2:0]    sticky_code;
      rrsp_rsp_type  expected_rsps[$];
      int            failures;

      function new();
         max_length    = MAX_LEN_RST;
         pos           = AT_ID;
         header_count  = 0;
         header_bytes  = '0;
         type_value    = '0;
         prev_id       = '0;
         cur_id        = '0;
         remaining     = '0;
         first_pending = 1'b0;
         sticky_code   = ERR_NONE;
         failures      = 0;
      endfunction

      function void set_max_length(logic [27:0] value);
         max_length = value;
      endfunction

      function void push_result(logic [1:0] kind, logic [7:0] body, logic first,
                                logic last, logic [2:0] code);
         rrsp_rsp_type r;
         r.kind            = kind;
         r.resource_type   = type_value[30:0];
         r.resource_id     = cur_id;
         r.body_byte       = body;
         r.first_of_record = first;
         r.last_of_record  = last;
         r.error_code      = code;
         expected_rsps.push_back(r);
      endfunction

      function void raise_error(logic [2:0] code);
         sticky_code = code;
         push_result(KIND_ERROR, 8'h00, 1'b0, 1'b0, code);
      endfunction

      // big-endian 7-bit groups of the collected header bytes
      function logic [27:0] header_value();
         logic [27:0] v;
         v = '0;
         for (int i = header_count - 1; i >= 0; i--)
            v = (v << 7) | header_bytes[8*i +: 7];
         return v;
      endfunction

      function void note_request(rrsp_req_type r);
         logic [27:0] value;
         logic [31:0] sum;
         logic        last_byte;
         // a latched error answers everything
         if (sticky_code != ERR_NONE) begin
            push_result(KIND_ERROR, 8'h00, 1'b0, 1'b0, sticky_code);
            return;
         end
         // end of stream is clean only between records
         if (r.mode == MODE_END) begin
            if (pos == AT_ID && header_count == 0)
               push_result(KIND_END, 8'h00, 1'b0, 1'b0, ERR_NONE);
            else
               raise_error(ERR_TRUNCATED);
            return;
         end
         // body bytes pass straight through
         if (pos == AT_BODY) begin
            last_byte = (remaining <= 28'd1);
            push_result(KIND_BODY, r.data_byte, first_pending, last_byte, ERR_NONE);
            first_pending = 1'b0;
            if (remaining != 0)
               remaining--;
            if (last_byte)
               pos = AT_ID;
            return;
         end
         // header byte: collect until a group without continuation
         header_bytes = {header_bytes[23:0], r.data_byte};
         header_count++;
         if (r.data_byte[7]) begin
            if (header_count < 4)
               return;
            if (pos == AT_LENGTH) begin
               raise_error(ERR_BAD_LEN);
               return;
            end
            // four continuation bytes in id position set the type
            type_value   = header_bytes & TYPE_MASK;
            prev_id      = '0;
            header_count = 0;
            header_bytes = '0;
            return;
         end
         value        = header_value();
         header_count = 0;
         header_bytes = '0;
         if (pos == AT_LENGTH) begin
            if (value > max_length)
               raise_error(ERR_TOO_LONG);
            else if (value == 0) begin
               pos = AT_ID;
               push_result(KIND_EMPTY, 8'h00, 1'b1, 1'b1, ERR_NONE);
            end else begin
               remaining     = value;
               first_pending = 1'b1;
               pos           = AT_BODY;
            end
         end else begin
            sum = {1'b0, prev_id} + {4'b0, value};
            if (sum[31])
               raise_error(ERR_ID_OVFL);
            else begin
               prev_id = sum[30:0];
               cur_id  = sum[30:0];
               pos     = AT_LENGTH;
            end
         end
      endfunction

      function void mismatch(string field, logic [31:0] want, logic [31:0] got);
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         failures++;
      endfunction

      function void check_response(rrsp_rsp_type got);
         rrsp_rsp_type want;
         if (expected_rsps.size() == 0) begin
            $display("%0t: response with no request pending, expected none, actual %h",
                     $time, got);
            failures++;
            return;
         end
         want = expected_rsps.pop_front();
         if (got.kind !== want.kind)
            mismatch("kind", want.kind, got.kind);
         if (got.resource_type !== want.resource_type)
            mismatch("resource_type", want.resource_type, got.resource_type);
         if (got.resource_id !== want.resource_id)
            mismatch("resource_id", want.resource_id, got.resource_id);
         if (got.body_byte !== want.body_byte)
            mismatch("body_byte", want.body_byte, got.body_byte);
         if (got.first_of_record !== want.first_of_record)
            mismatch("first_of_record", want.first_of_record, got.first_of_record);
         if (got.last_of_record !== want.last_of_record)
            mismatch("last_of_record", want.last_of_record, got.last_of_record);
         if (got.error_code !== want.error_code)
            mismatch("error_code", want.error_code, got.error_code);
      endfunction
   endclass

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   rrsp_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rrsp_rsp_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [27:0]  csr_wdata = '0;

   record_scoreboard scoreboard = new();

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_token     = 0;
   int hold_seen      = 0;
   int hold_left      = 0;
   int items_sent     = 0;
   int cycle_count    = 0;

   resource_record_stream_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // response side: check, then stall at random or hold off on request
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         scoreboard.check_response(rsp_data);
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("resource_record_stream_parser regression: fail");
         $finish;
      end
   end

   // one request, with random idle cycles ahead of it
   task automatic send_symbol(input logic mode, input logic [7:0] value);
      rrsp_req_type r;
      r.mode      = mode;
      r.data_byte = value;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      scoreboard.note_request(r);
      items_sent++;
   endtask

   // big-endian VLQ in exactly count bytes, zero padded at the front
   task automatic send_vlq(input int unsigned value, input int count);
      for (int i = count - 1; i >= 0; i--)
         send_symbol(MODE_DATA, {i != 0, 7'(value >> (7 * i))});
   endtask

   // shortest encoding most of the time, padded now and then
   function automatic int pick_vlq_width(int unsigned value);
      int shortest;
      shortest = (value < 32'h80) ? 1 : (value < 32'h4000) ? 2 :
                 (value < 32'h20_0000) ? 3 : 4;
      return ($urandom_range(2) == 0) ? $urandom_range(4, shortest) : shortest;
   endfunction

   // four continuation bytes: a type marker in id position
   task automatic send_type_marker();
      repeat (4) send_symbol(MODE_DATA, {1'b1, 7'($urandom)});
   endtask

   task automatic send_record(input int unsigned delta, input int unsigned length);
      send_vlq(delta, pick_vlq_width(delta));
      send_vlq(length, pick_vlq_width(length));
      repeat (length) send_symbol(MODE_DATA, 8'($urandom));
   endtask

   // well-formed record within the id range and the current length limit
   task automatic send_random_record();
      int unsigned delta;
      int unsigned length;
      int unsigned room;
      int unsigned cap;
      case ($urandom_range(9))
         0:          delta = 0;
         1, 2, 3, 4: delta = $urandom_range(127, 1);
         5, 6:       delta = $urandom_range(16383);
         7:          delta = $urandom_range(DELTA_MAX);
         default:    delta = DELTA_MAX;
      endcase
      room = ID_LIMIT - scoreboard.prev_id;
      if (delta > room)
         delta = room;
      cap = (scoreboard.max_length < 64) ? scoreboard.max_length : 64;
      case ($urandom_range(9))
         0:       length = $urandom_range(cap);
         1:       length = cap;
         default: length = $urandom_range((cap < 8) ? cap : 8);
      endcase
      send_record(delta, length);
   endtask

   // wait until every expected response is out, then let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      while (scoreboard.expected_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_length(input logic [27:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      scoreboard.set_max_length(value);
   endtask

   initial begin
      logic [27:0] limits [PHASES];
      logic [2:0]  error_pick;
      int unsigned delta;
      int          stop_at;

      limits[0] = LEN_MAX;
      limits[1] = 28'd0;
      limits[2] = 28'($urandom_range(16, 1));
      limits[3] = MAX_LEN_RST;
      limits[4] = 28'($urandom_range(LEN_MAX, 17));
      limits[5] = 28'd1;
      limits[6] = LEN_MAX;
      limits[7] = MAX_LEN_RST;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: end right after reset, extreme markers, ids and lengths
      send_symbol(MODE_END, 8'hff);
      repeat (4) send_symbol(MODE_DATA, 8'hff);
      send_vlq(DELTA_MAX, 4);
      send_symbol(MODE_DATA, 8'h00);
      send_symbol(MODE_DATA, 8'h00);
      send_symbol(MODE_DATA, 8'h02);
      send_symbol(MODE_DATA, 8'h00);
      send_symbol(MODE_DATA, 8'hff);
      repeat (4) send_symbol(MODE_DATA, 8'h80);
      send_symbol(MODE_DATA, 8'h7f);
      send_vlq(1, 4);
      send_symbol(MODE_DATA, 8'ha5);
      send_symbol(MODE_END, 8'h00);
      drain();

      // random phases: new length limit and idle pattern in each
      for (int p = 0; p < PHASES; p++) begin
         write_max_length(limits[p]);
         send_idle_pct  = (p % 4 == 1) ? 77 : (p % 4 == 3) ? 32 : 0;
         recv_stall_pct = (p % 4 == 2) ? 77 : (p % 4 == 3) ? 32 : 0;
         if (p % 4 == 0)
            hold_token <= hold_token + 1;
         stop_at = items_sent + RANDOM_ITEMS / PHASES;
         while (items_sent < stop_at) begin
            case ($urandom_range(19))
               0, 1:    send_type_marker();
               2:       send_symbol(MODE_END, 8'($urandom));
               default: send_random_record();
            endcase
         end
         drain();
      end

      // close with one error and check that it stays latched
      error_pick = 3'($urandom_range(4, 1));
      case (error_pick)
         ERR_BAD_LEN: begin
            send_vlq($urandom_range(127), 1);
            send_type_marker();
         end
         ERR_TRUNCATED: begin
            case ($urandom_range(3))
               0: repeat ($urandom_range(3, 1))
                     send_symbol(MODE_DATA, {1'b1, 7'($urandom)});
               1: send_vlq(0, 1);
               2: begin
                  send_vlq(0, 1);
                  repeat ($urandom_range(3, 1))
                     send_symbol(MODE_DATA, {1'b1, 7'($urandom)});
               end
               default: begin
                  send_vlq(0, 1);
                  send_vlq(5, 1);
                  send_symbol(MODE_DATA, 8'($urandom));
               end
            endcase
            send_symbol(MODE_END, 8'($urandom));
         end
         ERR_TOO_LONG: begin
            write_max_length(28'($urandom_range(1000)));
            send_vlq(0, 1);
            delta = $urandom_range(DELTA_MAX, scoreboard.max_length + 1);
            send_vlq(delta, pick_vlq_width(delta));
         end
         default: begin
            // climb to the top of the id range, then step past it
            send_type_marker();
            while (scoreboard.prev_id + DELTA_MAX <= ID_LIMIT)
               send_record(DELTA_MAX, 0);
            delta = $urandom_range(DELTA_MAX, ID_LIMIT - scoreboard.prev_id + 1);
            send_vlq(delta, pick_vlq_width(delta));
         end
      endcase
      repeat (6) send_symbol($urandom_range(1) ? MODE_END : MODE_DATA, 8'($urandom));
      drain();

      if (scoreboard.failures == 0 && scoreboard.expected_rsps.size() == 0)
         $display("resource_record_stream_parser regression: pass");
      else
         $display("resource_record_stream_parser regression: fail");
      $finish;
   end

endmodule
